@@ design/gated_axis_relax_normalize_core_defines.svh @@
// Assertion helpers for the core RTL file, which checks its own logic.
`ifndef GATED_AXIS_RELAX_NORMALIZE_CORE_DEFINES_SVH
`define GATED_AXIS_RELAX_NORMALIZE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define GARN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define GARN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/garn_pkg.sv @@
`timescale 1ns / 1ps

package garn_pkg;

  localparam int unsigned VecDim = 3;

  localparam int unsigned CompW   = 16;
  localparam int unsigned WideW   = 32;
  localparam int unsigned RW      = 33;
  localparam int unsigned MagW    = 32;
  localparam int unsigned N2W     = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned RemW    = 35;
  localparam int unsigned QW      = 13;
  localparam int unsigned NumW    = 45;
  localparam int unsigned FracSh  = 12;

  localparam int unsigned SqrtSteps    = RootW;
  localparam int unsigned SqrtPerStage = 4;
  localparam int unsigned SqrtStages   = SqrtSteps / SqrtPerStage;
  localparam int unsigned DivPerStage  = 4;
  localparam int unsigned DivStages    = (QW + DivPerStage - 1) / DivPerStage;

  typedef enum logic [1:0] {
    CFG_STEP_GAIN    = 2'd0,
    CFG_GATE_MODE    = 2'd1,
    CFG_VEL_LIMIT    = 2'd2,
    CFG_STRESS_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GATE_ALWAYS     = 2'd0,
    GATE_VEL        = 2'd1,
    GATE_VEL_STRESS = 2'd2
  } gate_mode_e;

  // Per-item flags and passthrough data that ride along the whole pipe.
  typedef struct packed {
    logic [2:0][CompW-1:0] axis;
    logic                  upd;
    logic [2:0]            neg;
    logic                  zn;
  } side_t;

  typedef struct packed {
    logic [N2W-1:0]   n;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  // One digit of the bit-pair square root.
  function automatic sqrt_t sqrt_step(sqrt_t st);
    sqrt_t            nx;
    logic [RemW-1:0]  rem_t;
    logic [RemW-1:0]  trial;
    rem_t = {st.rem[RemW-3:0], st.n[N2W-1 -: 2]};
    trial = {1'b0, st.root, 2'b01};
    nx.n  = {st.n[N2W-3:0], 2'b00};
    if (rem_t >= trial) begin
      nx.rem  = rem_t - trial;
      nx.root = {st.root[RootW-2:0], 1'b1};
    end else begin
      nx.rem  = rem_t;
      nx.root = {st.root[RootW-2:0], 1'b0};
    end
    return nx;
  endfunction

endpackage

@@ design/gated_axis_relax_normalize_core.sv @@
`timescale 1ns / 1ps
// Gated axis relaxation with renormalization, one cell per request.
// The slave channel takes the current axis, the goal direction, the velocity
// and two stress values; the master channel returns the new axis with two
// flags. Configuration goes through a plain write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) and must only be written while no request is in flight.
// The datapath is a 19-stage pipeline: gate and dot product, flip and
// relaxation, squares and norm, an 8-stage square root that resolves four
// root bits per stage, and a 4-stage divider that resolves up to four quotient
// bits per stage for all three components in parallel. One request can be
// accepted every cycle unless an output stall has backed up to the input.
// Each stage has its own valid bit and may take a new request whenever it
// is empty or the stage after it moves, so bubbles are squeezed out and
// input keeps flowing while a finished result waits on the output.
// When the receiver holds m_axis_tready low the stall backs up stage by
// stage; nothing is dropped or repeated. Reset empties the pipeline and
// clears all configuration registers to zero, so every request passes
// through unchanged until step_gain is written.
module gated_axis_relax_normalize_core
  import garn_pkg::*;
#(
  parameter int unsigned VECTOR_DIMENSION = VecDim
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // axis_x, axis_y, axis_z, goal_x, goal_y, goal_z, velocity,
  // principal_stress, vonmises_stress
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_x, new_y, new_z
  output logic [47:0]  m_axis_tdata,
  // was_updated, zero_norm
  output logic [1:0]   m_axis_tuser
);

`include "gated_axis_relax_normalize_core_defines.svh"

  localparam logic UseZ = (VECTOR_DIMENSION != 2);

  localparam int unsigned StIn    = 0;
  localparam int unsigned StFlip  = 1;
  localparam int unsigned StRlx   = 2;
  localparam int unsigned StSq    = 3;
  localparam int unsigned StN2    = 4;
  localparam int unsigned StSqrt0 = 5;
  localparam int unsigned StNum   = StSqrt0 + SqrtStages;
  localparam int unsigned StDiv0  = StNum + 1;
  localparam int unsigned StOut   = StDiv0 + DivStages;
  localparam int unsigned NSt     = StOut + 1;

  // Configuration registers.
  logic [15:0]      step_gain_q;
  logic [1:0]       gate_mode_q;
  logic [WideW-1:0] vel_limit_q;
  logic [WideW-1:0] stress_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_gain_q    <= '0;
      gate_mode_q    <= '0;
      vel_limit_q    <= '0;
      stress_limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_GAIN:    step_gain_q    <= cfg_wdata_i[15:0];
        CFG_GATE_MODE:    gate_mode_q    <= cfg_wdata_i[1:0];
        CFG_VEL_LIMIT:    vel_limit_q    <= cfg_wdata_i;
        CFG_STRESS_LIMIT: stress_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage load enables. A stage loads when it is empty
  // or when its own content moves on.
  logic [NSt-1:0] vld_q;
  logic [NSt:0]   en;

  assign en[NSt] = m_axis_tready;
  for (genvar k = 0; k < NSt; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSt; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // Side data travels with every stage.
  side_t side_q [NSt];
  side_t side_d [NSt];

  // Unpack the request.
  logic signed [CompW-1:0] in_a [3];
  logic signed [CompW-1:0] in_g [3];
  logic [WideW-1:0]        in_vel;
  logic signed [WideW-1:0] in_ps;
  logic signed [WideW-1:0] in_vs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_axis_tdata[i*CompW +: CompW];
      in_g[i] = s_axis_tdata[(i+3)*CompW +: CompW];
    end
    in_vel = s_axis_tdata[96 +: WideW];
    in_ps  = s_axis_tdata[128 +: WideW];
    in_vs  = s_axis_tdata[160 +: WideW];
  end

  // Stage 0: axis-goal products, stress magnitudes, velocity compare.
  logic signed [CompW-1:0] a0_q [3];
  logic signed [CompW-1:0] g0_q [3];
  logic signed [31:0]      prod0_q [3];
  logic [32:0]             dmag0_q;
  logic [WideW-1:0]        pmag0_q;
  logic                    velok0_q;
  logic signed [32:0]      pdiff;
  logic [32:0]             pdiff_n;
  logic [WideW-1:0]        ps_n;

  always_comb begin
    pdiff   = $signed({in_ps[31], in_ps}) - $signed({in_vs[31], in_vs});
    pdiff_n = 33'(-pdiff);
    ps_n    = 32'(-in_ps);
  end

  always_ff @(posedge clk_i) begin
    if (en[StIn]) begin
      for (int i = 0; i < 3; i++) begin
        a0_q[i]    <= in_a[i];
        g0_q[i]    <= in_g[i];
        prod0_q[i] <= (i < 2 || UseZ) ? in_a[i] * in_g[i] : 32'sd0;
      end
      dmag0_q  <= pdiff[32] ? pdiff_n : pdiff;
      pmag0_q  <= in_ps[31] ? ps_n : in_ps;
      velok0_q <= in_vel < vel_limit_q;
    end
  end

  // Stage 1: sign flip from the dot product, stress threshold product.
  logic signed [16:0] af1_q [3];
  logic signed [15:0] g1_q [3];
  logic [63:0]        plim1_q;
  logic [32:0]        dmag1_q;
  logic               velok1_q;
  logic signed [33:0] dot;

  assign dot = 34'(prod0_q[0]) + 34'(prod0_q[1]) + 34'(prod0_q[2]);

  always_ff @(posedge clk_i) begin
    if (en[StFlip]) begin
      for (int i = 0; i < 3; i++) begin
        af1_q[i] <= dot[33] ? -{a0_q[i][15], a0_q[i]} : {a0_q[i][15], a0_q[i]};
        g1_q[i]  <= g0_q[i];
      end
      plim1_q  <= stress_limit_q * pmag0_q;
      dmag1_q  <= dmag0_q;
      velok1_q <= velok0_q;
    end
  end

  // Stage 2: gate decision and relaxation toward the goal.
  logic signed [RW-1:0] r2_q [3];
  logic                 gate;
  logic signed [17:0]   gdiff [3];
  logic signed [34:0]   gprod [3];
  logic signed [35:0]   rsum [3];

  always_comb begin
    unique case (gate_mode_q)
      GATE_ALWAYS:     gate = 1'b1;
      GATE_VEL:        gate = velok1_q;
      GATE_VEL_STRESS: gate = velok1_q && ({15'b0, dmag1_q, 16'b0} > plim1_q);
      default:         gate = 1'b0;
    endcase
    for (int i = 0; i < 3; i++) begin
      gdiff[i] = 18'(g1_q[i]) - 18'(af1_q[i]);
      gprod[i] = $signed({1'b0, step_gain_q}) * gdiff[i];
      rsum[i]  = $signed({{3{af1_q[i][16]}}, af1_q[i], 16'h0}) + 36'(gprod[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StRlx]) begin
      for (int i = 0; i < 3; i++) begin
        r2_q[i] <= rsum[i][RW-1:0];
      end
    end
  end

  // Stage 3: magnitudes and squares.
  logic [MagW-1:0]      mag3_q [3];
  logic [N2W-1:0]       sq3_q [3];
  logic [MagW-1:0]      rmag [3];
  logic signed [RW-1:0] rneg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rneg[i] = -r2_q[i];
      rmag[i] = r2_q[i][RW-1] ? rneg[i][MagW-1:0] : r2_q[i][MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StSq]) begin
      for (int i = 0; i < 3; i++) begin
        mag3_q[i] <= rmag[i];
        sq3_q[i]  <= (i < 2 || UseZ) ? rmag[i] * rmag[i] : '0;
      end
    end
  end

  // Stage 4: squared norm.
  logic [MagW-1:0] mag4_q [3];
  logic [N2W-1:0]  n2_q;
  logic [N2W-1:0]  n2_sum;

  assign n2_sum = sq3_q[0] + sq3_q[1] + sq3_q[2];

  always_ff @(posedge clk_i) begin
    if (en[StN2]) begin
      mag4_q <= mag3_q;
      n2_q   <= n2_sum;
    end
  end

  // Square root stages.
  sqrt_t           sqrt_q [SqrtStages];
  sqrt_t           sqrt_d [SqrtStages];
  logic [MagW-1:0] sqm_q [SqrtStages][3];

  for (genvar j = 0; j < SqrtStages; j++) begin : g_sqrt
    sqrt_t           src;
    logic [MagW-1:0] sqm_src [3];
    if (j == 0) begin : g_first
      assign src     = '{n: n2_q, rem: '0, root: '0};
      assign sqm_src = mag4_q;
    end else begin : g_next
      assign src     = sqrt_q[j-1];
      assign sqm_src = sqm_q[j-1];
    end

    always_comb begin
      sqrt_t st;
      st = src;
      for (int t = 0; t < SqrtPerStage; t++) begin
        st = sqrt_step(st);
      end
      sqrt_d[j] = st;
    end

    always_ff @(posedge clk_i) begin
      if (en[StSqrt0 + j]) begin
        sqrt_q[j] <= sqrt_d[j];
        sqm_q[j]  <= sqm_src;
      end
    end
  end

  // Numerator stage: scale by 4096 and add half the divisor for rounding.
  logic [NumW-1:0]  num_q [3];
  logic [RootW-1:0] s_q;
  logic [RootW-1:0] root_f;

  assign root_f = sqrt_q[SqrtStages-1].root;

  always_ff @(posedge clk_i) begin
    if (en[StNum]) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= {1'b0, sqm_q[SqrtStages-1][i], 12'h0} + NumW'(root_f >> 1);
      end
      s_q <= root_f;
    end
  end

  // Divider stages, up to four quotient bits each, highest bit first.
  logic [NumW-1:0]  dv_num_q [DivStages][3];
  logic [QW-1:0]    dv_quo_q [DivStages][3];
  logic [RootW-1:0] dv_s_q [DivStages];

  for (genvar j = 0; j < DivStages; j++) begin : g_div
    logic [NumW-1:0]  num_src [3];
    logic [QW-1:0]    quo_src [3];
    logic [RootW-1:0] s_src;
    logic [NumW-1:0]  num_nx [3];
    logic [QW-1:0]    quo_nx [3];

    if (j == 0) begin : g_first
      assign num_src = num_q;
      assign quo_src = '{default: '0};
      assign s_src   = s_q;
    end else begin : g_next
      assign num_src = dv_num_q[j-1];
      assign quo_src = dv_quo_q[j-1];
      assign s_src   = dv_s_q[j-1];
    end

    always_comb begin
      logic [NumW-1:0] sk;
      int              kb;
      num_nx = num_src;
      quo_nx = quo_src;
      for (int t = 0; t < DivPerStage; t++) begin
        kb = int'(QW) - 1 - j * int'(DivPerStage) - t;
        if (kb >= 0) begin
          sk = NumW'(s_src) << kb;
          for (int i = 0; i < 3; i++) begin
            if (num_nx[i] >= sk) begin
              num_nx[i]     = num_nx[i] - sk;
              quo_nx[i][kb] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[StDiv0 + j]) begin
        dv_num_q[j] <= num_nx;
        dv_quo_q[j] <= quo_nx;
        dv_s_q[j]   <= s_src;
      end
    end
  end

  // Output stage: sign, zero length and passthrough selection.
  logic [2:0][CompW-1:0] out_q;
  logic                  upd_q;
  logic                  zn_q;
  side_t                 sd_last;
  logic [CompW-1:0]      qext [3];
  logic [2:0][CompW-1:0] out_d;

  assign sd_last = side_q[StOut-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qext[i] = {3'b0, dv_quo_q[DivStages-1][i]};
      if (!sd_last.upd || (i == 2 && !UseZ)) begin
        out_d[i] = sd_last.axis[i];
      end else if (sd_last.zn) begin
        out_d[i] = '0;
      end else begin
        out_d[i] = sd_last.neg[i] ? (~qext[i] + 16'd1) : qext[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StOut]) begin
      out_q <= out_d;
      upd_q <= sd_last.upd;
      zn_q  <= sd_last.upd & sd_last.zn;
    end
  end

  // Side data: filled in as the facts become known.
  always_comb begin
    for (int k = 0; k < NSt; k++) begin
      side_d[k] = (k == 0) ? side_t'('0) : side_q[(k == 0) ? 0 : k-1];
    end
    for (int i = 0; i < 3; i++) begin
      side_d[StIn].axis[i] = in_a[i];
      side_d[StSq].neg[i]  = r2_q[i][RW-1];
    end
    side_d[StRlx].upd = (step_gain_q != '0) && gate;
    side_d[StN2].zn   = (n2_sum == '0);
  end

  for (genvar k = 0; k < NSt; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  assign m_axis_tvalid = vld_q[StOut];
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = {zn_q, upd_q};

  `GARN_ASSERT_NOW(a_zn_needs_upd, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "zero norm flagged without an update")
  `GARN_ASSERT_NOW(a_zn_zero_out, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[31:0] == 32'h0, "zero norm result is not zero")
  `GARN_ASSERT_NOW(a_quo_bound, vld_q[StOut-1] && !sd_last.zn, dv_quo_q[DivStages-1][0] <= 13'd4096 && dv_quo_q[DivStages-1][1] <= 13'd4096, "normalized component above one")
  `GARN_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, vld_q[StIn], "accepted request missing from the first stage")

endmodule

@@ tb/sv/gated_axis_relax_normalize_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the gated axis relaxation core. Requests are driven on the
// slave stream with random gaps, results are taken from the master stream
// with random stalls, and every result is compared with a prediction made
// from the same request and the current register settings.
module gated_axis_relax_normalize_core_tb;
  import garn_pkg::*;

  localparam int unsigned LimitCycles = 2000000;
  localparam int unsigned NumRandom   = 2000;

  // One cell as it travels on the slave stream.
  typedef struct {
    logic signed [15:0] axis [3];
    logic signed [15:0] goal [3];
    logic [31:0]        vel;
    logic signed [31:0] pstress;
    logic signed [31:0] vstress;
  } cell_t;

  // One new axis with its two flags.
  typedef struct {
    logic [15:0] comp [3];
    logic        updated;
    logic        zero_len;
  } new_axis_t;

  // A directed row: the cell, and where it is plain, the typed-in answer.
  typedef struct {
    cell_t     req;
    bit        typed;
    new_axis_t answer;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [31:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // axis_x, axis_y, axis_z, goal_x, goal_y, goal_z, velocity,
  // principal_stress, vonmises_stress
  logic [191:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // new_x, new_y, new_z
  logic [47:0]  m_axis_tdata;
  // was_updated, zero_norm
  logic [1:0]   m_axis_tuser;

  // The testbench keeps its own copy of the four registers.
  logic [15:0] gain_q;
  logic [1:0]  mode_q;
  logic [31:0] vel_lim_q;
  logic [31:0] ratio_lim_q;

  new_axis_t   pending_axes[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          hold_off;

  gated_axis_relax_normalize_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Bit-pair integer square root, floor of the true root.
  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Decides whether the update is allowed for this cell.
  function automatic bit gate_passes(cell_t c);
    longint     p;
    longint     v;
    logic [63:0] diff;
    logic [63:0] lim;
    p = c.pstress;
    v = c.vstress;
    if (mode_q == GATE_ALWAYS) return 1'b1;
    if (mode_q != GATE_VEL && mode_q != GATE_VEL_STRESS) return 1'b0;
    if (!(c.vel < vel_lim_q)) return 1'b0;
    if (mode_q == GATE_VEL) return 1'b1;
    diff = ((p - v) < 0 ? -(p - v) : (p - v)) << 16;
    lim  = 64'(ratio_lim_q) * 64'(p < 0 ? -p : p);
    return diff > lim;
  endfunction

  // Works out the relaxed and renormalized axis for one cell.
  function automatic new_axis_t relax_axis(cell_t c);
    new_axis_t   o;
    longint      a [3];
    longint      g [3];
    longint      r [3];
    longint      dot;
    logic [63:0] n2;
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] q;
    for (int d = 0; d < 3; d++) begin
      a[d] = c.axis[d];
      g[d] = c.goal[d];
      o.comp[d] = c.axis[d];
    end
    o.updated  = 1'b0;
    o.zero_len = 1'b0;
    if (gain_q == 0 || !gate_passes(c)) return o;
    o.updated = 1'b1;
    dot = 0;
    for (int d = 0; d < VecDim; d++) dot += a[d] * g[d];
    if (dot < 0) for (int d = 0; d < VecDim; d++) a[d] = -a[d];
    n2 = '0;
    for (int d = 0; d < VecDim; d++) begin
      r[d] = a[d] * 65536 + longint'(gain_q) * (g[d] - a[d]);
      m    = r[d] < 0 ? -r[d] : r[d];
      n2  += m * m;
    end
    if (n2 == 0) begin
      for (int d = 0; d < VecDim; d++) o.comp[d] = '0;
      o.zero_len = 1'b1;
      return o;
    end
    s = floor_root(n2);
    for (int d = 0; d < VecDim; d++) begin
      m = r[d] < 0 ? -r[d] : r[d];
      q = (m * 4096 + s / 2) / s;
      o.comp[d] = r[d] < 0 ? 16'(-q) : 16'(q);
    end
    return o;
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int unsigned kind;
    for (int d = 0; d < 3; d++) begin
      kind = $urandom_range(0, 9);
      // Mostly unit-scale vectors, sometimes full-range or extreme values.
      if (kind < 6) c.axis[d] = 16'($urandom_range(0, 8192)) - 16'sd4096;
      else if (kind < 9) c.axis[d] = 16'($urandom);
      else c.axis[d] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      kind = $urandom_range(0, 9);
      if (kind < 6) c.goal[d] = 16'($urandom_range(0, 8192)) - 16'sd4096;
      else if (kind < 9) c.goal[d] = 16'($urandom);
      else c.goal[d] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
    end
    c.vel = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0004_0000);
    c.pstress = $urandom;
    c.vstress = $urandom_range(0, 3) == 0 ? c.pstress : $urandom;
    if ($urandom_range(0, 7) == 0) c.pstress = '0;
    if ($urandom_range(0, 3) == 0) begin
      c.pstress = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      c.vstress = c.pstress + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    end
    return c;
  endfunction

  // Writes one register; only called while the pipeline is empty.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_STEP_GAIN:    gain_q      = value[15:0];
      CFG_GATE_MODE:    mode_q      = value[1:0];
      CFG_VEL_LIMIT:    vel_lim_q   = value;
      CFG_STRESS_LIMIT: ratio_lim_q = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] gain, logic [1:0] mode, logic [31:0] vlim,
                         logic [31:0] rlim);
    write_reg(CFG_STEP_GAIN, {16'd0, gain});
    write_reg(CFG_GATE_MODE, {30'd0, mode});
    write_reg(CFG_VEL_LIMIT, vlim);
    write_reg(CFG_STRESS_LIMIT, rlim);
  endtask

  // Stops offering requests and waits until every expected result has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_axes.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  // Offers one request after a random gap and waits for it to be taken.
  task automatic send_cell(cell_t c, bit typed, new_axis_t answer);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.vstress, c.pstress, c.vel, c.goal[2], c.goal[1], c.goal[0],
                      c.axis[2], c.axis[1], c.axis[0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_axes.push_back(typed ? answer : relax_axis(c));
  endtask

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && m_axis_tvalid) begin
        stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          if (!hold_off) m_axis_tready <= 1'b1;
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    new_axis_t want;
    new_axis_t got;
    bit        bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.comp[0]  = m_axis_tdata[15:0];
      got.comp[1]  = m_axis_tdata[31:16];
      got.comp[2]  = m_axis_tdata[47:32];
      got.updated  = m_axis_tuser[0];
      got.zero_len = m_axis_tuser[1];
      if (pending_axes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result with no request pending: %h %b",
                                       m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_axes.pop_front();
        bad  = 1'b0;
        for (int d = 0; d < 3; d++) if (want.comp[d] !== got.comp[d]) bad = 1'b1;
        if (want.updated !== got.updated || want.zero_len !== got.zero_len) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h %h upd %b zn %b, got %h %h %h upd %b zn %b",
                     want.comp[0], want.comp[1], want.comp[2], want.updated,
                     want.zero_len, got.comp[0], got.comp[1], got.comp[2],
                     got.updated, got.zero_len);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic cell_t mk(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, logic signed [15:0] gx,
                               logic signed [15:0] gy, logic signed [15:0] gz,
                               logic [31:0] vel, logic signed [31:0] ps,
                               logic signed [31:0] vs);
    cell_t c;
    c.axis[0] = ax; c.axis[1] = ay; c.axis[2] = az;
    c.goal[0] = gx; c.goal[1] = gy; c.goal[2] = gz;
    c.vel = vel; c.pstress = ps; c.vstress = vs;
    return c;
  endfunction

  function automatic new_axis_t ans(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                    logic upd, logic zn);
    new_axis_t o;
    o.comp[0] = x; o.comp[1] = y; o.comp[2] = z;
    o.updated = upd; o.zero_len = zn;
    return o;
  endfunction

  // Main sequence: directed phases under several settings, then random traffic.
  initial begin
    row_t      rows[$];
    row_t      rw;
    new_axis_t none;
    cell_t     c;
    none = ans('0, '0, '0, 1'b0, 1'b0);
    mismatches    = 0;
    cycle_count   = 0;
    hold_off      = 1'b0;
    gain_q = '0; mode_q = '0; vel_lim_q = '0; ratio_lim_q = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_STEP_GAIN;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the gain is zero, so every cell passes through unchanged.
    rw.typed = 1'b1;
    rw.req = mk(16'sh7fff, 16'sh8000, 16'sh1000, 16'sh1000, 16'sh0, 16'sh0, '1,
                32'sh7fffffff, 32'sh80000000);
    rw.answer = ans(16'h7fff, 16'h8000, 16'h1000, 1'b0, 1'b0);
    rows.push_back(rw);
    rw.req = mk(16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, '0, '0, '0);
    rw.answer = ans('0, '0, '0, 1'b0, 1'b0);
    rows.push_back(rw);
    foreach (rows[i]) send_cell(rows[i].req, rows[i].typed, rows[i].answer);
    drain();
    rows.delete();

    // Full gain, always update: the axis lands on the goal direction.
    set_all(16'hffff, GATE_ALWAYS, '0, '0);
    rw.req = mk(16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, '0, '0, '0);
    rw.answer = ans('0, '0, '0, 1'b1, 1'b1);
    rows.push_back(rw);
    rw.typed = 1'b0;
    rw.req = mk(16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, '0, '0, '0);
    rows.push_back(rw);
    // Negative dot product flips the axis first, including the most negative value.
    rw.req = mk(16'sh8000, 16'sh0, 16'sh0, 16'sh1000, 16'sh0100, 16'sh0, '0, '0, '0);
    rows.push_back(rw);
    rw.req = mk(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                '1, '0, '0);
    rows.push_back(rw);
    rw.req = mk(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                '0, '0, '0);
    rows.push_back(rw);
    rw.req = mk(16'sh0001, 16'shffff, 16'sh0, 16'sh0, 16'sh0, 16'sh0001, '0, '0, '0);
    rows.push_back(rw);
    foreach (rows[i]) send_cell(rows[i].req, rows[i].typed, rows[i].answer);
    drain();
    rows.delete();

    // Velocity and stress gating, including zero principal stress.
    set_all(16'h0001, GATE_VEL_STRESS, 32'h0001_0000, 32'h0000_8000);
    rw.req = mk(16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, 32'h0001_0000,
                32'sh10000, 32'sh0);
    rw.typed = 1'b1;
    rw.answer = ans(16'h1000, 16'h0, 16'h0, 1'b0, 1'b0);
    rows.push_back(rw);
    rw.typed = 1'b0;
    rw.req = mk(16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, 32'h0000_ffff,
                32'sh0, 32'sh1);
    rows.push_back(rw);
    rw.req = mk(16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, 32'h0,
                32'sh0, 32'sh0);
    rows.push_back(rw);
    rw.req = mk(16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, 32'h0,
                32'sh10000, 32'sh18001);
    rows.push_back(rw);
    rw.req = mk(16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, 32'h0,
                32'sh10000, 32'sh18000);
    rows.push_back(rw);
    rw.req = mk(16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, 32'h0,
                32'sh80000000, 32'sh7fffffff);
    rows.push_back(rw);
    foreach (rows[i]) send_cell(rows[i].req, rows[i].typed, rows[i].answer);
    drain();
    rows.delete();

    // The unused gate mode keeps the gate closed.
    set_all(16'h8000, 2'd3, '1, '0);
    c = mk(16'sh0800, 16'sh0800, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, '0, '0, '0);
    send_cell(c, 1'b1, ans(16'h0800, 16'h0800, 16'h0, 1'b0, 1'b0));
    drain();

    // Velocity-only gate with the largest limit.
    set_all(16'h4000, GATE_VEL, '1, '1);
    c = mk(16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh0, '1, '0, '0);
    send_cell(c, 1'b1, ans(16'h1000, 16'h0, 16'h0, 1'b0, 1'b0));
    c.vel = 32'hffff_fffe;
    send_cell(c, 1'b0, none);
    drain();

    // Random phases under new random settings, the last with full gain; the first
    // also holds the receiver off long enough for the pipeline to fill and stall.
    for (int ph = 0; ph < 8; ph++) begin
      set_all(ph == 7 ? 16'hffff : 16'($urandom), 2'($urandom_range(0, 3)),
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0004_0000),
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0002_0000));
      if (ph == 0) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < NumRandom / 8; i++) send_cell(random_cell(), 1'b0, none);
      drain();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/garn_pkg.sv
design/gated_axis_relax_normalize_core.sv
tb/sv/gated_axis_relax_normalize_core_tb.sv
